### design/acu_pkg.sv
// Shared types and constants of the accumulator calculator unit.
// Holds the item structs, the opcode and status codes and the datapath command set.
// Depends on nothing.
package acu_pkg;

    // Fixed-point format: signed 32-bit values with FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 16;

    // Division works on the left magnitude shifted up by FRAC_BITS + 1.
    localparam int DIV_W = 32 + FRAC_BITS + 1;

    // Square root takes two radicand bits per step.
    localparam int SQ_PAIRS = (33 + FRAC_BITS) / 2;
    localparam int SQ_XW = 2 * SQ_PAIRS;

    // Number of log2 fraction bits and the log10(2) constant in Q.28.
    localparam int LOG_FRAC = 30;
    localparam logic [26:0] LOG10_2_Q28 = 27'd80807124;

    // Width of the iteration counter in the controller.
    localparam int CNT_W = 6;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_SQUARE,
        OP_SQRT,
        OP_LOG10,
        OP_CLEAR
    } op_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SAT,
        ST_DIV0,
        ST_DOMAIN,
        ST_CLEAR
    } status_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] first_value;
        logic signed [31:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [2:0]         status;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_ADDSUB,
        DP_MUL,
        DP_MUL_RND,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_RND,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_SQRT_RND,
        DP_LOG_INIT,
        DP_LOG_NORM,
        DP_LOG_SQ,
        DP_LOG_BIT,
        DP_LOG_MLO,
        DP_LOG_MHI,
        DP_LOG_RND,
        DP_FIN_STORE,
        DP_FIN_DIV0,
        DP_FIN_DOM,
        DP_FIN_CLEAR
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic nv_zero;
        logic nv_neg;
        logic norm_done;
        logic out_valid;
    } dp_stat_t;

endpackage

### design/acu_datapath.sv
// Datapath of the accumulator calculator unit: operand, held and work registers,
// the shared multiplier, the bit-serial divider, square root and log10, and the output register.
// Depends on acu_pkg.
module acu_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  acu_pkg::dp_cmd_t     dp_cmd,
    input  acu_pkg::in_item_t    cmd,
    input  logic                 res_ready,
    output acu_pkg::dp_stat_t    dp_stat,
    output acu_pkg::out_item_t   res,
    output logic                 res_valid
);

    localparam int DW = acu_pkg::DIV_W;
    localparam int FB = acu_pkg::FRAC_BITS;

    acu_pkg::op_t        op_reg, op_next;
    logic signed [31:0]  lft_reg, lft_next;
    logic signed [31:0]  nv_reg, nv_next;
    logic [31:0]         held_reg, held_next;
    logic                held_valid_reg, held_valid_next;
    logic                neg_reg, neg_next;
    logic [63:0]         mag_reg, mag_next;
    logic [49:0]         rem_reg, rem_next;
    logic [DW-1:0]       quo_reg, quo_next;
    logic signed [6:0]   ip_reg, ip_next;
    logic                res_valid_reg, res_valid_next;
    acu_pkg::out_item_t  res_reg, res_next;

    logic [31:0]         lmag, nmag, amag;
    logic signed [31:0]  mul_a;
    logic signed [32:0]  sum;
    logic [32:0]         div_t;
    logic                div_ge;
    logic [33:0]         sq_t, sq_trial;
    logic                sq_ge;
    logic [61:0]         log_sq;
    logic [31:0]         log_mm;
    logic signed [36:0]  log_l;
    logic [36:0]         log_lm;
    logic [31:0]         sat_val;
    acu_pkg::status_t    sat_st;

    // Operand magnitudes and the per-step arithmetic.
    always_comb
    begin
        lmag = lft_reg[31] ? 32'(-lft_reg) : 32'(lft_reg);
        nmag = nv_reg[31] ? 32'(-nv_reg) : 32'(nv_reg);
        mul_a = (op_reg == acu_pkg::OP_SQUARE) ? nv_reg : lft_reg;
        amag = mul_a[31] ? 32'(-mul_a) : 32'(mul_a);
        if (op_reg == acu_pkg::OP_SUB)
        begin
            sum = {lft_reg[31], lft_reg} - {nv_reg[31], nv_reg};
        end
        else
        begin
            sum = {lft_reg[31], lft_reg} + {nv_reg[31], nv_reg};
        end
        div_t = {rem_reg[31:0], quo_reg[DW-1]};
        div_ge = div_t >= {1'b0, nmag};
        sq_t = {rem_reg[31:0], quo_reg[acu_pkg::SQ_XW-1 -: 2]};
        sq_trial = {mag_reg[31:0], 2'b01};
        sq_ge = sq_t >= sq_trial;
        log_sq = quo_reg[30:0] * quo_reg[30:0];
        log_mm = mag_reg[61:30];
        log_l = {ip_reg, rem_reg[29:0]};
        log_lm = log_l[36] ? 37'(-log_l) : 37'(log_l);
    end

    // Saturation of the signed magnitude to the 32-bit range.
    always_comb
    begin
        sat_st = acu_pkg::ST_OK;
        if (!neg_reg)
        begin
            if (mag_reg > 64'h0000_0000_7FFF_FFFF)
            begin
                sat_val = 32'h7FFF_FFFF;
                sat_st = acu_pkg::ST_SAT;
            end
            else
            begin
                sat_val = mag_reg[31:0];
            end
        end
        else
        begin
            if (mag_reg > 64'h0000_0000_8000_0000)
            begin
                sat_val = 32'h8000_0000;
                sat_st = acu_pkg::ST_SAT;
            end
            else
            begin
                sat_val = 32'(-mag_reg[31:0]);
            end
        end
    end

    // Next-state logic under the controller's command.
    always_comb
    begin
        op_next = op_reg;
        lft_next = lft_reg;
        nv_next = nv_reg;
        held_next = held_reg;
        held_valid_next = held_valid_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        ip_next = ip_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        case (dp_cmd)
            acu_pkg::DP_LOAD:
            begin
                op_next = acu_pkg::op_t'(cmd.opcode);
                lft_next = held_valid_reg ? held_reg : cmd.first_value;
                nv_next = cmd.new_value;
            end
            acu_pkg::DP_ADDSUB:
            begin
                neg_next = sum[32];
                mag_next = sum[32] ? 64'(-sum) : 64'(sum);
            end
            acu_pkg::DP_MUL:
            begin
                neg_next = mul_a[31] ^ nv_reg[31];
                mag_next = amag * nmag;
            end
            acu_pkg::DP_MUL_RND:
            begin
                mag_next = (mag_reg + (64'd1 << (FB - 1))) >> FB;
            end
            acu_pkg::DP_DIV_INIT:
            begin
                neg_next = lft_reg[31] ^ nv_reg[31];
                rem_next = '0;
                quo_next = DW'(lmag) << (FB + 1);
            end
            acu_pkg::DP_DIV_STEP:
            begin
                rem_next = div_ge ? 50'(div_t - {1'b0, nmag}) : 50'(div_t);
                quo_next = {quo_reg[DW-2:0], div_ge};
            end
            acu_pkg::DP_DIV_RND:
            begin
                mag_next = (64'(quo_reg) + 64'd1) >> 1;
            end
            acu_pkg::DP_SQRT_INIT:
            begin
                neg_next = 1'b0;
                mag_next = '0;
                rem_next = '0;
                quo_next = DW'(nmag) << FB;
            end
            acu_pkg::DP_SQRT_STEP:
            begin
                rem_next = sq_ge ? 50'(sq_t - sq_trial) : 50'(sq_t);
                mag_next = {mag_reg[62:0], sq_ge};
                quo_next = quo_reg << 2;
            end
            acu_pkg::DP_SQRT_RND:
            begin
                if (64'(rem_reg) > mag_reg)
                begin
                    mag_next = mag_reg + 64'd1;
                end
            end
            acu_pkg::DP_LOG_INIT:
            begin
                neg_next = 1'b0;
                rem_next = '0;
                quo_next = DW'(nmag);
                ip_next = 7'(30 - FB);
            end
            acu_pkg::DP_LOG_NORM:
            begin
                quo_next = quo_reg << 1;
                ip_next = ip_reg - 7'sd1;
            end
            acu_pkg::DP_LOG_SQ:
            begin
                mag_next = 64'(log_sq);
            end
            acu_pkg::DP_LOG_BIT:
            begin
                quo_next = log_mm[31] ? DW'(log_mm[31:1]) : DW'(log_mm[30:0]);
                rem_next = {rem_reg[48:0], log_mm[31]};
            end
            acu_pkg::DP_LOG_MLO:
            begin
                neg_next = ip_reg[6];
                mag_next = 64'(log_lm[17:0] * acu_pkg::LOG10_2_Q28);
            end
            acu_pkg::DP_LOG_MHI:
            begin
                mag_next = mag_reg + (64'(log_lm[35:18] * acu_pkg::LOG10_2_Q28) << 18);
            end
            acu_pkg::DP_LOG_RND:
            begin
                mag_next = (mag_reg + (64'd1 << (57 - FB))) >> (58 - FB);
            end
            acu_pkg::DP_FIN_STORE:
            begin
                held_next = sat_val;
                held_valid_next = 1'b1;
                res_next.result = sat_val;
                res_next.status = sat_st;
                res_valid_next = 1'b1;
            end
            acu_pkg::DP_FIN_DIV0:
            begin
                res_next.result = held_reg;
                res_next.status = acu_pkg::ST_DIV0;
                res_valid_next = 1'b1;
            end
            acu_pkg::DP_FIN_DOM:
            begin
                res_next.result = held_reg;
                res_next.status = acu_pkg::ST_DOMAIN;
                res_valid_next = 1'b1;
            end
            acu_pkg::DP_FIN_CLEAR:
            begin
                held_next = '0;
                held_valid_next = 1'b0;
                res_next.result = '0;
                res_next.status = acu_pkg::ST_CLEAR;
                res_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control state: held flag, held value and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            held_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            held_valid_reg <= held_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Work and payload registers.
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        lft_reg <= lft_next;
        nv_reg <= nv_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ip_reg <= ip_next;
        res_reg <= res_next;
    end

    assign dp_stat.op = op_reg;
    assign dp_stat.nv_zero = (nv_reg == 32'sd0);
    assign dp_stat.nv_neg = nv_reg[31];
    assign dp_stat.norm_done = quo_reg[30];
    assign dp_stat.out_valid = res_valid_reg;
    assign res = res_reg;
    assign res_valid = res_valid_reg;

endmodule

### design/acu_controller.sv
// Controller of the accumulator calculator unit: sequences the datapath per opcode.
// Counts iterations of division, square root and log10 and waits for the output slot.
// Depends on acu_pkg.
module acu_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic                res_ready,
    input  acu_pkg::dp_stat_t   dp_stat,
    output acu_pkg::dp_cmd_t    dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADDSUB,
        S_MUL,
        S_MUL_RND,
        S_DIV,
        S_DIV_RND,
        S_SQRT,
        S_SQRT_RND,
        S_LOG_NORM,
        S_LOG_SQ,
        S_LOG_BIT,
        S_LOG_MLO,
        S_LOG_MHI,
        S_LOG_RND,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [acu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    acu_pkg::dp_cmd_t    fin_reg, fin_next;
    logic                slot_free;

    assign slot_free = !dp_stat.out_valid || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    // Next state and the command for the current cycle.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        fin_next = fin_reg;
        dp_cmd = acu_pkg::DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    dp_cmd = acu_pkg::DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                fin_next = acu_pkg::DP_FIN_STORE;
                case (dp_stat.op)
                    acu_pkg::OP_ADD, acu_pkg::OP_SUB:
                    begin
                        state_next = S_ADDSUB;
                    end
                    acu_pkg::OP_MUL, acu_pkg::OP_SQUARE:
                    begin
                        state_next = S_MUL;
                    end
                    acu_pkg::OP_DIV:
                    begin
                        if (dp_stat.nv_zero)
                        begin
                            fin_next = acu_pkg::DP_FIN_DIV0;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            dp_cmd = acu_pkg::DP_DIV_INIT;
                            state_next = S_DIV;
                        end
                    end
                    acu_pkg::OP_SQRT:
                    begin
                        if (dp_stat.nv_neg)
                        begin
                            fin_next = acu_pkg::DP_FIN_DOM;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            dp_cmd = acu_pkg::DP_SQRT_INIT;
                            state_next = S_SQRT;
                        end
                    end
                    acu_pkg::OP_LOG10:
                    begin
                        if (dp_stat.nv_neg || dp_stat.nv_zero)
                        begin
                            fin_next = acu_pkg::DP_FIN_DOM;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            dp_cmd = acu_pkg::DP_LOG_INIT;
                            state_next = S_LOG_NORM;
                        end
                    end
                    default:
                    begin
                        fin_next = acu_pkg::DP_FIN_CLEAR;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_ADDSUB:
            begin
                dp_cmd = acu_pkg::DP_ADDSUB;
                state_next = S_FIN;
            end
            S_MUL:
            begin
                dp_cmd = acu_pkg::DP_MUL;
                state_next = S_MUL_RND;
            end
            S_MUL_RND:
            begin
                dp_cmd = acu_pkg::DP_MUL_RND;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                dp_cmd = acu_pkg::DP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == acu_pkg::CNT_W'(acu_pkg::DIV_W - 1))
                begin
                    state_next = S_DIV_RND;
                end
            end
            S_DIV_RND:
            begin
                dp_cmd = acu_pkg::DP_DIV_RND;
                state_next = S_FIN;
            end
            S_SQRT:
            begin
                dp_cmd = acu_pkg::DP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == acu_pkg::CNT_W'(acu_pkg::SQ_PAIRS - 1))
                begin
                    state_next = S_SQRT_RND;
                end
            end
            S_SQRT_RND:
            begin
                dp_cmd = acu_pkg::DP_SQRT_RND;
                state_next = S_FIN;
            end
            S_LOG_NORM:
            begin
                // Shift until the leading one reaches the mantissa's top bit.
                if (dp_stat.norm_done)
                begin
                    state_next = S_LOG_SQ;
                end
                else
                begin
                    dp_cmd = acu_pkg::DP_LOG_NORM;
                end
            end
            S_LOG_SQ:
            begin
                dp_cmd = acu_pkg::DP_LOG_SQ;
                state_next = S_LOG_BIT;
            end
            S_LOG_BIT:
            begin
                dp_cmd = acu_pkg::DP_LOG_BIT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == acu_pkg::CNT_W'(acu_pkg::LOG_FRAC - 1))
                begin
                    state_next = S_LOG_MLO;
                end
                else
                begin
                    state_next = S_LOG_SQ;
                end
            end
            S_LOG_MLO:
            begin
                dp_cmd = acu_pkg::DP_LOG_MLO;
                state_next = S_LOG_MHI;
            end
            S_LOG_MHI:
            begin
                dp_cmd = acu_pkg::DP_LOG_MHI;
                state_next = S_LOG_RND;
            end
            S_LOG_RND:
            begin
                dp_cmd = acu_pkg::DP_LOG_RND;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // The result goes out once the output register is free.
                if (slot_free)
                begin
                    dp_cmd = fin_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, iteration counter and pending finish command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            fin_reg <= acu_pkg::DP_FIN_STORE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    // An accepted item always goes to dispatch next.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> state_reg == S_DISPATCH)
        else $error("accepted item did not reach dispatch");

    // The division counter never runs past the last quotient bit.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= acu_pkg::CNT_W'(acu_pkg::DIV_W - 1))
        else $error("division counter overran");

    // A finished item waits while the output register is held.
    a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && dp_stat.out_valid && !res_ready |=> state_reg == S_FIN)
        else $error("result issued into a full output register");

endmodule

### design/accumulator_calculator_unit.sv
// Top level of the accumulator calculator unit: controller plus datapath.
// Depends on acu_pkg, acu_controller and acu_datapath.
//
//   channel | signals                  | payload
//   --------+--------------------------+-------------------------------------
//   cmd     | cmd_valid, cmd_ready     | opcode, first_value, new_value
//   res     | res_valid, res_ready     | result, status
//
// One item at a time. Add and subtract take one add step, multiply and square
// a multiply and a rounding step, division 49 restoring quotient steps,
// square root 24 steps on two radicand bits each, log10 up to 30 normalizing
// shifts, 30 square-and-compare steps and 3 to scale. Errors and clear go
// from dispatch straight to finish. A new item can be taken in the cycle a
// result reaches the output register, which holds it until res_ready.
// Reset empties the accumulator and the output register.
module accumulator_calculator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  acu_pkg::in_item_t   cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output acu_pkg::out_item_t  res
);

    acu_pkg::dp_cmd_t  dp_cmd;
    acu_pkg::dp_stat_t dp_stat;

    acu_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_ready (res_ready),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    acu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .cmd       (cmd),
        .res_ready (res_ready),
        .dp_stat   (dp_stat),
        .res       (res),
        .res_valid (res_valid)
    );

endmodule

### dv/tb.sv
// Testbench for the accumulator calculator unit: random and directed opcodes, checked
// against a fixed-point calculator model held in a small result-tracking class.
// Depends on acu_pkg and the RTL of accumulator_calculator_unit.
`timescale 1ns / 100ps

module tb;

    // Fixed-point calculator model with a queue of pending results.
    class calc_tracker;
        logic [31:0]        acc;
        bit                 acc_valid;
        acu_pkg::out_item_t pending[$];
        int                 mismatches;
        int                 checked;

        function new();
            acc = 0;
            acc_valid = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint fx_mul(longint a, longint b);
            longint p;
            p = (mag(a) * mag(b) + (64'sd1 <<< (acu_pkg::FRAC_BITS - 1)))
                >>> acu_pkg::FRAC_BITS;
            return ((a < 0) != (b < 0)) ? -p : p;
        endfunction

        function longint fx_div(longint a, longint b);
            logic [63:0] q;
            q = (64'(mag(a)) << (acu_pkg::FRAC_BITS + 1)) / 64'(mag(b));
            q = (q + 1) >> 1;
            return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function longint fx_sqrt(longint v);
            logic [63:0] x, r, b, rem;
            x = 64'(v) << acu_pkg::FRAC_BITS;
            rem = x;
            r = 0;
            b = 64'd1 << 62;
            while (b > rem) b = b >> 2;
            while (b != 0)
            begin
                if (rem >= r + b)
                begin
                    rem = rem - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            if (x - r * r > r) r = r + 1;
            return longint'(r);
        endfunction

        function longint fx_log10(longint v);
            logic [63:0] x, m, lm, prod;
            int p;
            longint l;
            x = 64'(v);
            p = 30;
            while (p > 0 && x[p] == 1'b0) p--;
            m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
            l = longint'(p - acu_pkg::FRAC_BITS) * (64'sd1 <<< 30);
            for (int i = 29; i >= 0; i--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    l += 64'sd1 <<< i;
                    m = m >> 1;
                end
            end
            lm = 64'(mag(l));
            prod = lm * 64'(acu_pkg::LOG10_2_Q28);
            prod = (prod + (64'd1 << (57 - acu_pkg::FRAC_BITS))) >> (58 - acu_pkg::FRAC_BITS);
            return (l < 0) ? -longint'(prod) : longint'(prod);
        endfunction

        // Works out the result of one accepted command item and queues it.
        function void note_command(acu_pkg::in_item_t it);
            longint nv, left, r;
            acu_pkg::status_t st;
            bit keep;
            acu_pkg::out_item_t o;
            nv = longint'(it.new_value);
            left = acc_valid ? longint'($signed(acc)) : longint'(it.first_value);
            st = acu_pkg::ST_OK;
            keep = 1;
            r = 0;
            case (acu_pkg::op_t'(it.opcode))
                acu_pkg::OP_ADD: r = left + nv;
                acu_pkg::OP_SUB: r = left - nv;
                acu_pkg::OP_MUL: r = fx_mul(left, nv);
                acu_pkg::OP_DIV:
                    if (nv == 0)
                    begin
                        st = acu_pkg::ST_DIV0;
                        keep = 0;
                    end
                    else
                        r = fx_div(left, nv);
                acu_pkg::OP_SQUARE: r = fx_mul(nv, nv);
                acu_pkg::OP_SQRT:
                    if (nv < 0)
                    begin
                        st = acu_pkg::ST_DOMAIN;
                        keep = 0;
                    end
                    else
                        r = fx_sqrt(nv);
                acu_pkg::OP_LOG10:
                    if (nv <= 0)
                    begin
                        st = acu_pkg::ST_DOMAIN;
                        keep = 0;
                    end
                    else
                        r = fx_log10(nv);
                default:
                begin
                    acc = 0;
                    acc_valid = 0;
                    st = acu_pkg::ST_CLEAR;
                    keep = 0;
                end
            endcase
            if (keep)
            begin
                if (r > 64'sh7FFFFFFF)
                begin
                    acc = 32'h7FFFFFFF;
                    st = acu_pkg::ST_SAT;
                end
                else if (r < -64'sh80000000)
                begin
                    acc = 32'h80000000;
                    st = acu_pkg::ST_SAT;
                end
                else
                    acc = r[31:0];
                acc_valid = 1;
            end
            o.result = acc;
            o.status = st;
            pending.push_back(o);
        endfunction

        // Compares one accepted result item with the oldest expectation.
        function void check_result(acu_pkg::out_item_t got);
            acu_pkg::out_item_t exp_item;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item: result=%h status=%0d",
                             got.result, got.status);
                return;
            end
            exp_item = pending.pop_front();
            if (got.result !== exp_item.result || got.status !== exp_item.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected result=%h status=%0d, got result=%h status=%0d",
                             exp_item.result, exp_item.status, got.result, got.status);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    acu_pkg::in_item_t  cmd;
    logic               res_valid;
    logic               res_ready;
    acu_pkg::out_item_t res;

    calc_tracker tracker;
    int          cycles;
    int          sent;
    bit          hold_off;
    bit          stim_done;

    accumulator_calculator_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Picks a gap length: mostly short, sometimes long.
    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    // Random operand, biased toward corners and small magnitudes.
    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // Offers one command item and waits for it to be accepted.
    task automatic send_item(acu_pkg::op_t op, logic [31:0] fv, logic [31:0] nv);
        acu_pkg::in_item_t it;
        it.opcode = op;
        it.first_value = fv;
        it.new_value = nv;
        cmd_valid <= 1'b1;
        cmd <= it;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        tracker.note_command(it);
        sent++;
    endtask

    // Sends one item, then either keeps valid high or drops it for a gap.
    task automatic send_with_gap(acu_pkg::op_t op, logic [31:0] fv, logic [31:0] nv);
        int g;
        send_item(op, fv, nv);
        g = pick_gap();
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Directed part, then random chains.
    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        sent = 0;
        stim_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_with_gap(acu_pkg::OP_ADD, 32'h00010000, 32'h00020000);
        send_with_gap(acu_pkg::OP_SUB, 32'h0, 32'h00008000);
        send_with_gap(acu_pkg::OP_MUL, 32'h0, 32'hFFFE0000);
        send_with_gap(acu_pkg::OP_DIV, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_DIV, 32'h0, 32'h00030000);
        send_with_gap(acu_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_ADD, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_with_gap(acu_pkg::OP_SUB, 32'h0, 32'h7FFFFFFF);
        send_with_gap(acu_pkg::OP_SUB, 32'h0, 32'h7FFFFFFF);
        send_with_gap(acu_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_MUL, 32'h80000000, 32'h80000000);
        send_with_gap(acu_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_DIV, 32'h80000000, 32'h00000001);
        send_with_gap(acu_pkg::OP_SQUARE, 32'h0, 32'h80000000);
        send_with_gap(acu_pkg::OP_SQRT, 32'h0, 32'hFFFFFFFF);
        send_with_gap(acu_pkg::OP_SQRT, 32'h0, 32'h7FFFFFFF);
        send_with_gap(acu_pkg::OP_SQRT, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_LOG10, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_LOG10, 32'h0, 32'h80000000);
        send_with_gap(acu_pkg::OP_LOG10, 32'h0, 32'h00000001);
        send_with_gap(acu_pkg::OP_LOG10, 32'h0, 32'h7FFFFFFF);
        send_with_gap(acu_pkg::OP_LOG10, 32'h0, 32'h000A0000);
        send_with_gap(acu_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_with_gap(acu_pkg::OP_DIV, 32'h00010000, 32'h00030000);

        // Pause until every expected result has come back.
        cmd_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);

        // Random chains, usually started by a clear.
        while (sent < 1400)
        begin
            if ($urandom_range(0, 9) == 0)
                send_with_gap(acu_pkg::OP_CLEAR, pick_value(), pick_value());
            else
                send_with_gap(acu_pkg::op_t'($urandom_range(0, 6)), pick_value(),
                              pick_value());
        end
        cmd_valid <= 1'b0;
        stim_done = 1;
    end

    // Long receiver hold-off once, counted in cycles here.
    initial
    begin
        hold_off = 0;
        wait (sent >= 300);
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
    end

    // Result side: random stalls, check on each accepted item.
    initial
    begin
        int g;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = pick_gap();
            if (hold_off || g > 0)
            begin
                res_ready <= 1'b0;
                repeat (g > 0 ? g : 1) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                @(posedge clk);
                if (res_valid) tracker.check_result(res);
            end
        end
    end

    // Run end and timeout.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("DONE: errors detected");
                $finish;
            end
            if (stim_done && tracker.pending.size() == 0)
            begin
                repeat (200) @(posedge clk);
                $display("Sent %0d command items over all opcodes; checked %0d results.",
                         sent, tracker.checked);
                if (tracker.mismatches == 0 && tracker.pending.size() == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
                $finish;
            end
        end
    end
endmodule
